/* rtl/rrc_pkg.sv */
// shared types and constants for the range remap chain
`timescale 1ns / 1ps

package rrc_pkg;

    localparam int OPCODE_W    = 2;
    localparam int STAGE_SEL_W = 3;
    localparam int ROW_SEL_W   = 5;
    localparam int FIELD_W     = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_rrc_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_rrc_state;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_rrc_mem_ctl;

endpackage

/* rtl/rrc_in_if.sv */
// input channel: load, query and clear words
`timescale 1ns / 1ps

interface rrc_in_if import rrc_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [STAGE_SEL_W-1:0] stage_sel;
    logic [ROW_SEL_W-1:0]   row_sel;
    logic                   row_enable;
    logic [FIELD_W-1:0]     src_base;
    logic [FIELD_W-1:0]     dst_base;
    logic [FIELD_W-1:0]     span;
    logic [FIELD_W-1:0]     query_value;

    modport source (
        output valid, opcode, stage_sel, row_sel, row_enable,
               src_base, dst_base, span, query_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, stage_sel, row_sel, row_enable,
               src_base, dst_base, span, query_value,
        output ready
    );

endinterface

/* rtl/rrc_out_if.sv */
// output channel: translated value, running minimum and overflow
`timescale 1ns / 1ps

interface rrc_out_if import rrc_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] mapped_value;
    logic [FIELD_W-1:0] running_min;
    logic               overflow;

    modport source (
        output valid, mapped_value, running_min, overflow,
        input  ready
    );

    modport sink (
        input  valid, mapped_value, running_min, overflow,
        output ready
    );

endinterface

/* rtl/rrc_table.sv */
// row table: one synchronous memory of rows plus resettable valid bits
`timescale 1ns / 1ps

module rrc_table import rrc_pkg::*; #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32,
    parameter int ADDR_W     = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_rrc_mem_ctl            i_ctl,
    input  logic [ADDR_W-1:0]       i_addr,
    input  logic                    i_wr_valid,
    input  logic [3*VALUE_BITS-1:0] i_wr_data,
    output logic [3*VALUE_BITS-1:0] o_rd_data,
    output logic                    o_rd_valid
);

    logic [3*VALUE_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]        r_valid;
    logic [3*VALUE_BITS-1:0] r_rd_data;
    logic                    r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr) begin
                r_valid[i_addr] <= i_wr_valid;
            end
            if (i_ctl.rd) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;

endmodule

/* rtl/rrc_walk.sv */
// sequencer: loads rows, walks a query through every stage, keeps the minimum
`timescale 1ns / 1ps

module rrc_walk import rrc_pkg::*; #(
    parameter int STAGES     = 8,
    parameter int ROWS       = 32,
    parameter int VALUE_BITS = 32,
    parameter int ADDR_W     = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    rrc_in_if.sink                  i_in,
    rrc_out_if.source               o_out,
    output t_rrc_mem_ctl            o_mem_ctl,
    output logic [ADDR_W-1:0]       o_mem_addr,
    output logic                    o_wr_valid,
    output logic [3*VALUE_BITS-1:0] o_wr_data,
    input  logic [3*VALUE_BITS-1:0] i_rd_data,
    input  logic                    i_rd_valid
);

    localparam int STG_W = (STAGES > 1) ? $clog2(STAGES) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int VB    = VALUE_BITS;

    t_rrc_state       r_state, n_state;
    logic [STG_W-1:0] r_is_stage, n_is_stage;
    logic [ROW_W-1:0] r_is_row, n_is_row;
    logic             r_is_done, n_is_done;
    logic             r_ev, n_ev;
    logic [STG_W-1:0] r_ev_stage, n_ev_stage;
    logic             r_ev_final, n_ev_final;
    logic [VB-1:0]    r_value, n_value;
    logic             r_ovf, n_ovf;
    logic [VB-1:0]    r_min, n_min;
    logic             r_out_vld, n_out_vld;
    logic [VB-1:0]    r_out_val, n_out_val;
    logic [VB-1:0]    r_out_min, n_out_min;
    logic             r_out_ovf, n_out_ovf;

    logic [VB-1:0] rd_src, rd_span, rd_dst;
    logic [VB:0]   row_hi;
    logic [VB:0]   row_res;
    logic          hit;
    logic          accept;
    logic          load_ok;
    logic [VB-1:0] min_upd;

    assign rd_src  = i_rd_data[VB-1:0];
    assign rd_span = i_rd_data[2*VB-1:VB];
    assign rd_dst  = i_rd_data[3*VB-1:2*VB];

    // half-open range test with a one bit wider upper bound
    assign row_hi  = {1'b0, rd_src} + {1'b0, rd_span};
    assign hit     = r_ev && i_rd_valid && (r_value >= rd_src) && ({1'b0, r_value} < row_hi);
    assign row_res = {1'b0, rd_dst} + {1'b0, r_value - rd_src};

    assign accept  = i_in.valid && i_in.ready;
    assign load_ok = (32'(i_in.stage_sel) < STAGES) && (32'(i_in.row_sel) < ROWS);
    assign min_upd = (r_value < r_min) ? r_value : r_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_done <= 1'b0;
            r_ev      <= 1'b0;
            r_min     <= '1;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_done <= n_is_done;
            r_ev      <= n_ev;
            r_min     <= n_min;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_stage <= n_is_stage;
        r_is_row   <= n_is_row;
        r_ev_stage <= n_ev_stage;
        r_ev_final <= n_ev_final;
        r_value    <= n_value;
        r_ovf      <= n_ovf;
        r_out_val  <= n_out_val;
        r_out_min  <= n_out_min;
        r_out_ovf  <= n_out_ovf;
    end

    always_comb begin
        n_state    = r_state;
        n_is_stage = r_is_stage;
        n_is_row   = r_is_row;
        n_is_done  = r_is_done;
        n_ev       = 1'b0;
        n_ev_stage = r_ev_stage;
        n_ev_final = r_ev_final;
        n_value    = r_value;
        n_ovf      = r_ovf;
        n_min      = r_min;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_val  = r_out_val;
        n_out_min  = r_out_min;
        n_out_ovf  = r_out_ovf;

        o_mem_ctl  = '0;
        o_mem_addr = ADDR_W'(32'(r_is_stage) * ROWS + 32'(r_is_row));
        o_wr_valid = i_in.row_enable;
        o_wr_data  = {VB'(i_in.dst_base), VB'(i_in.span), VB'(i_in.src_base)};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_rrc_op'(i_in.opcode))
                        OP_LOAD: begin
                            o_mem_ctl.wr = load_ok;
                            o_mem_addr   = ADDR_W'(32'(i_in.stage_sel) * ROWS
                                                   + 32'(i_in.row_sel));
                        end
                        OP_QUERY: begin
                            n_state    = S_RUN;
                            n_value    = VB'(i_in.query_value);
                            n_ovf      = 1'b0;
                            n_is_stage = '0;
                            n_is_row   = '0;
                            n_is_done  = 1'b0;
                        end
                        OP_CLEAR: begin
                            n_min = '1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (hit) begin
                    // rebase, no read this cycle, restart at row 0 of the next stage or finish after the last
                    n_value = row_res[VB-1:0];
                    n_ovf   = r_ovf | row_res[VB];
                    if (r_ev_stage == STG_W'(STAGES - 1)) begin
                        n_state = S_DONE;
                    end else begin
                        n_is_stage = STG_W'(r_ev_stage + 1'b1);
                        n_is_row   = '0;
                        n_is_done  = 1'b0;
                    end
                end else if (r_ev && r_ev_final) begin
                    n_state = S_DONE;
                end else if (!r_is_done) begin
                    o_mem_ctl.rd = 1'b1;
                    n_ev         = 1'b1;
                    n_ev_stage   = r_is_stage;
                    n_ev_final   = (r_is_stage == STG_W'(STAGES - 1))
                                   && (r_is_row == ROW_W'(ROWS - 1));
                    if (r_is_row == ROW_W'(ROWS - 1)) begin
                        n_is_row = '0;
                        if (r_is_stage == STG_W'(STAGES - 1)) begin
                            n_is_done = 1'b1;
                        end else begin
                            n_is_stage = STG_W'(r_is_stage + 1'b1);
                        end
                    end else begin
                        n_is_row = ROW_W'(r_is_row + 1'b1);
                    end
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld = 1'b1;
                    n_out_val = r_value;
                    n_out_min = min_upd;
                    n_out_ovf = r_ovf;
                    n_min     = min_upd;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.mapped_value = FIELD_W'(r_out_val);
    assign o_out.running_min  = FIELD_W'(r_out_min);
    assign o_out.overflow     = r_out_ovf;

endmodule

/* rtl/range_remap_chain_unit.sv */
// top level of the range remap chain
//
//  channel  dir  handshake     payload
//  i_in     in   valid/ready   opcode, stage_sel, row_sel, row_enable, src_base,
//                              dst_base, span, query_value
//  o_out    out  valid/ready   mapped_value, running_min, overflow
//
// loads and clears leave the sequencer idle; a query holds it from accept to the next
// accept, its walk paced by the single row memory port that reads one row per cycle
// while the query walks, except in a cycle that sees a row hit
// a row hit ends that stage early; after a hit in any stage but the last, the table
// is not read in the hit cycle, and the walk goes on at row 0 of the next stage
// reset clears the valid bits, the running minimum and the sequencer
// a result waiting on o_out does not block the next word on i_in; a finished
// query waits only while the previous result is still unread
`timescale 1ns / 1ps

module range_remap_chain_unit import rrc_pkg::*; #(
    parameter int STAGES     = 8,
    parameter int ROWS       = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rrc_in_if.sink    i_in,
    rrc_out_if.source o_out
);

    localparam int DEPTH  = STAGES * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_rrc_mem_ctl            mem_ctl;
    logic [ADDR_W-1:0]       mem_addr;
    logic                    wr_valid;
    logic [3*VALUE_BITS-1:0] wr_data;
    logic [3*VALUE_BITS-1:0] rd_data;
    logic                    rd_valid;

    rrc_walk #(
        .STAGES     (STAGES),
        .ROWS       (ROWS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_mem_ctl  (mem_ctl),
        .o_mem_addr (mem_addr),
        .o_wr_valid (wr_valid),
        .o_wr_data  (wr_data),
        .i_rd_data  (rd_data),
        .i_rd_valid (rd_valid)
    );

    rrc_table #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_addr     (mem_addr),
        .i_wr_valid (wr_valid),
        .i_wr_data  (wr_data),
        .o_rd_data  (rd_data),
        .o_rd_valid (rd_valid)
    );

    // the reported minimum includes the value it is reported with
    a_min_le_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.running_min <= o_out.mapped_value))
        else $error("running minimum above mapped value");

    // a query occupies the sequencer, so no word is taken right after it
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.opcode == OP_QUERY)) |=> !i_in.ready)
        else $error("word taken while a query is walking");

    // a result needs at least one table read, never ready the cycle after accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.opcode == OP_QUERY)) |=> !$rose(o_out.valid))
        else $error("result appeared without a table walk");

    // the table is never read and written in the same cycle
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr && mem_ctl.rd))
        else $error("row memory read and written together");

endmodule

/* dv/tb_range_remap_chain_unit.sv */
// testbench for range_remap_chain_unit: directed and random words, scoreboard on results
`timescale 1ns / 1ps

module tb_range_remap_chain_unit;
    import rrc_pkg::*;

    localparam int N_STAGES    = 8;
    localparam int N_ROWS      = 32;
    localparam int N_RANDOM    = 1730;
    localparam int N_TAIL      = 250;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_WAIT  = N_STAGES * N_ROWS + 8;
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
    localparam logic [FIELD_W-1:0]  WIN_BASE = 32'h0001_0000;

    typedef struct {
        logic [OPCODE_W-1:0]    opcode;
        logic [STAGE_SEL_W-1:0] stage_sel;
        logic [ROW_SEL_W-1:0]   row_sel;
        logic                   row_enable;
        logic [FIELD_W-1:0]     src_base;
        logic [FIELD_W-1:0]     dst_base;
        logic [FIELD_W-1:0]     span;
        logic [FIELD_W-1:0]     query_value;
    } t_cmd_word;

    typedef struct {
        logic [FIELD_W-1:0] mapped;
        logic [FIELD_W-1:0] min_val;
        logic               ovf;
    } t_map_result;

    class remap_chain_tracker;
        logic [FIELD_W-1:0] row_src [N_STAGES*N_ROWS];
        logic [FIELD_W-1:0] row_dst [N_STAGES*N_ROWS];
        logic [FIELD_W-1:0] row_len [N_STAGES*N_ROWS];
        bit                 row_on  [N_STAGES*N_ROWS];
        logic [FIELD_W-1:0] lowest_seen;
        t_map_result        pending_maps [$];
        int n_errors, n_results, n_loads, n_queries, n_clears, n_wraps;

        function new();
            foreach (row_on[i]) row_on[i] = 1'b0;
            lowest_seen = '1;
            n_errors = 0;
            n_results = 0;
            n_loads = 0;
            n_queries = 0;
            n_clears = 0;
            n_wraps = 0;
        endfunction

        // apply one accepted word to the shadow tables, queue a result for a query
        function void note_word(t_cmd_word w);
            t_map_result      r;
            logic [FIELD_W:0] cur;
            logic [FIELD_W:0] lo;
            logic [FIELD_W:0] hi;
            logic [FIELD_W:0] res;
            bit               hit;
            int               idx;
            case (w.opcode)
                OP_LOAD: begin
                    idx = int'(w.stage_sel) * N_ROWS + int'(w.row_sel);
                    row_on[idx]  = w.row_enable;
                    row_src[idx] = w.src_base;
                    row_dst[idx] = w.dst_base;
                    row_len[idx] = w.span;
                    n_loads++;
                end
                OP_QUERY: begin
                    cur = {1'b0, w.query_value};
                    r.ovf = 1'b0;
                    for (int s = 0; s < N_STAGES; s++) begin
                        hit = 1'b0;
                        for (int k = 0; k < N_ROWS && !hit; k++) begin
                            idx = s * N_ROWS + k;
                            if (row_on[idx]) begin
                                // range end is one bit wider so it never wraps
                                lo = {1'b0, row_src[idx]};
                                hi = lo + {1'b0, row_len[idx]};
                                if (cur >= lo && cur < hi) begin
                                    res = {1'b0, row_dst[idx]} + (cur - lo);
                                    if (res[FIELD_W]) r.ovf = 1'b1;
                                    cur = {1'b0, res[FIELD_W-1:0]};
                                    hit = 1'b1;
                                end
                            end
                        end
                    end
                    if (cur[FIELD_W-1:0] < lowest_seen) lowest_seen = cur[FIELD_W-1:0];
                    r.mapped  = cur[FIELD_W-1:0];
                    r.min_val = lowest_seen;
                    pending_maps = {pending_maps, r};
                    n_queries++;
                    if (r.ovf) n_wraps++;
                end
                OP_CLEAR: begin
                    lowest_seen = '1;
                    n_clears++;
                end
                default: begin
                end
            endcase
        endfunction

        function void flag(string what, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
            n_errors++;
            $error("%s expected %h got %h", what, want, got);
        endfunction

        function void check_mapped(t_map_result got);
            t_map_result want;
            n_results++;
            if (pending_maps.size() == 0) begin
                n_errors++;
                $error("result with no query waiting: mapped_value %h", got.mapped);
                return;
            end
            want = pending_maps.pop_front();
            if (got.mapped !== want.mapped) flag("mapped_value", want.mapped, got.mapped);
            if (got.min_val !== want.min_val) flag("running_min", want.min_val, got.min_val);
            if (got.ovf !== want.ovf) begin
                flag("overflow", FIELD_W'(want.ovf), FIELD_W'(got.ovf));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   quiet_tail = 1'b0;
    int   in_idle_pct = 20;

    rrc_in_if  in_if ();
    rrc_out_if out_if ();

    remap_chain_tracker tracker = new();

    range_remap_chain_unit #(
        .STAGES     (N_STAGES),
        .ROWS       (N_ROWS),
        .VALUE_BITS (FIELD_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("range_remap_chain_unit verification failed");
        $finish;
    end

    function automatic t_cmd_word mk_word(logic [OPCODE_W-1:0] op, int stage, int row,
                                          bit en, logic [FIELD_W-1:0] src,
                                          logic [FIELD_W-1:0] dst, logic [FIELD_W-1:0] len,
                                          logic [FIELD_W-1:0] q);
        t_cmd_word w;
        w.opcode      = op;
        w.stage_sel   = stage[STAGE_SEL_W-1:0];
        w.row_sel     = row[ROW_SEL_W-1:0];
        w.row_enable  = en;
        w.src_base    = src;
        w.dst_base    = dst;
        w.span        = len;
        w.query_value = q;
        return w;
    endfunction

    // mostly a narrow window so ranges and queries meet, some full-width and near-top values
    function automatic logic [FIELD_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) return WIN_BASE + $urandom_range(0, 4095);
        else if (sel < 85) return $urandom();
        else return 32'hFFFF_FFFF - $urandom_range(0, 4095);
    endfunction

    function automatic t_cmd_word rand_word();
        t_cmd_word   w;
        int unsigned pick;
        w.stage_sel   = STAGE_SEL_W'($urandom_range(0, 7));
        w.row_sel     = ROW_SEL_W'($urandom_range(0, 31));
        w.row_enable  = 1'($urandom_range(0, 1));
        w.src_base    = $urandom();
        w.dst_base    = $urandom();
        w.span        = $urandom();
        w.query_value = $urandom();
        pick = $urandom_range(0, 99);
        if (pick < 40) w.opcode = OP_LOAD;
        else if (pick < 90) w.opcode = OP_QUERY;
        else if (pick < 96) w.opcode = OP_CLEAR;
        else w.opcode = OP_SPARE;
        if (w.opcode == OP_LOAD) begin
            // low rows win, so most loads land there
            if ($urandom_range(0, 3) != 0) w.row_sel = ROW_SEL_W'($urandom_range(0, 7));
            w.row_enable = ($urandom_range(0, 99) < 85);
            w.src_base   = pick_value();
            w.dst_base   = pick_value();
            pick = $urandom_range(0, 99);
            if (pick < 10) w.span = '0;
            else if (pick < 80) w.span = $urandom_range(1, 1024);
            else if (pick < 90) w.span = $urandom();
            else w.span = 32'hFFFF_FFFF - $urandom_range(0, 255);
        end else if (w.opcode == OP_QUERY) begin
            w.query_value = pick_value();
        end
        return w;
    endfunction

    task automatic push_word(input t_cmd_word w);
        in_if.valid       <= 1'b1;
        in_if.opcode      <= w.opcode;
        in_if.stage_sel   <= w.stage_sel;
        in_if.row_sel     <= w.row_sel;
        in_if.row_enable  <= w.row_enable;
        in_if.src_base    <= w.src_base;
        in_if.dst_base    <= w.dst_base;
        in_if.span        <= w.span;
        in_if.query_value <= w.query_value;
        do @(posedge i_clk); while (!in_if.ready);
        tracker.note_word(w);
        if (!quiet_tail && $urandom_range(0, 99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        int unsigned stall_pct;
        int unsigned seg_cycles;
        bit          long_hold_done;
        t_map_result got;
        stall_left = 0;
        stall_pct = 0;
        seg_cycles = 0;
        long_hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                got.mapped  = out_if.mapped_value;
                got.min_val = out_if.running_min;
                got.ovf     = out_if.overflow;
                tracker.check_mapped(got);
            end
            if (seg_cycles == 0) begin
                seg_cycles = 150;
                stall_pct = 10 * $urandom_range(0, 2);
            end
            seg_cycles--;
            // one long hold so finished queries back up into the input
            if (!long_hold_done && tracker.n_results >= 300) begin
                stall_left = 1200;
                long_hold_done = 1'b1;
            end else if (stall_left == 0 && !quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 15);
            end
            out_if.ready <= (stall_left == 0);
            if (stall_left != 0) stall_left--;
        end
    end

    initial begin : stimulus
        t_cmd_word w;
        int        counted;
        in_if.valid       <= 1'b0;
        in_if.opcode      <= OP_LOAD;
        in_if.stage_sel   <= '0;
        in_if.row_sel     <= '0;
        in_if.row_enable  <= 1'b0;
        in_if.src_base    <= '0;
        in_if.dst_base    <= '0;
        in_if.span        <= '0;
        in_if.query_value <= '0;
        do @(posedge i_clk); while (!i_rst_n);

        // empty tables pass values through, minimum starts at all ones
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        push_word(mk_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        // zero span matches nothing
        push_word(mk_word(OP_LOAD, 0, 0, 1, 100, 1000, 0, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 100));
        // destination plus offset wraps past 32 bits
        push_word(mk_word(OP_LOAD, 0, 0, 1, 100, 32'hFFFF_FFF0, 50, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 120));
        // overlapping lower row takes priority, top value without wrap
        push_word(mk_word(OP_LOAD, 0, 1, 1, 110, 5, 10, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 115));
        push_word(mk_word(OP_LOAD, 0, 0, 0, 100, 32'hFFFF_FFF0, 50, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 115));
        // range end beyond 32 bits
        push_word(mk_word(OP_LOAD, 1, 31, 1, 32'hFFFF_FF00, 16, 32'hFFFF_FFFF, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        push_word(mk_word(OP_LOAD, 7, 5, 1, 10, 0, 1, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 115));
        // half-open end of a range
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 120));
        push_word(mk_word(OP_SPARE, 7, 31, 1, '1, '1, '1, '1));
        push_word(mk_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 119));
        push_word(mk_word(OP_LOAD, 7, 31, 1, '1, '1, '1, '1));
        push_word(mk_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFE));

        counted = 0;
        while (counted < N_RANDOM) begin
            if (counted % 100 == 0) in_idle_pct = 10 * $urandom_range(0, 3);
            if (counted >= N_RANDOM - N_TAIL) quiet_tail = 1'b1;
            w = rand_word();
            push_word(w);
            if (w.opcode != OP_SPARE) counted++;
        end
        in_if.valid <= 1'b0;

        while (tracker.pending_maps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run covered %0d row loads, %0d queries (%0d wrapped), %0d minimum clears",
                 tracker.n_loads, tracker.n_queries, tracker.n_wraps, tracker.n_clears);
        $display("%0d results checked, %0d mismatches", tracker.n_results, tracker.n_errors);
        if (tracker.n_errors == 0 && tracker.pending_maps.size() == 0) begin
            $display("range_remap_chain_unit verification clean");
        end else begin
            $display("range_remap_chain_unit verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/rrc_pkg.sv
rtl/rrc_in_if.sv
rtl/rrc_out_if.sv
rtl/rrc_table.sv
rtl/rrc_walk.sv
rtl/range_remap_chain_unit.sv
dv/tb_range_remap_chain_unit.sv
